// ===== rtl/cpca_pkg.sv =====
package cpca_pkg;

	localparam int REQ_W    = 3;
	localparam int BASE_W   = 16;
	localparam int SLEN_W   = 17;
	localparam int PSTART_W = 21;
	localparam int TGT_W    = 20;
	localparam int OPC_W    = 4;
	localparam int OPLEN_W  = 28;
	localparam int RADDR_W  = 16;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = 8;

	localparam logic [CNT_W-1:0]    SAT_COUNT      = 8'hFF;
	localparam logic [PSTART_W-1:0] PATH_MAX_TOTAL = '1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_OP     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

	// cigar op codes that do something
	localparam logic [OPC_W-1:0] OP_M  = 4'd0;
	localparam logic [OPC_W-1:0] OP_D  = 4'd2;
	localparam logic [OPC_W-1:0] OP_N  = 4'd3;
	localparam logic [OPC_W-1:0] OP_EQ = 4'd7;
	localparam logic [OPC_W-1:0] OP_X  = 4'd8;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NO_WALK = 2'd3;

	typedef struct packed {
		logic [BASE_W-1:0]   base;
		logic [SLEN_W-1:0]   len;
		logic [PSTART_W-1:0] start;
		logic                rev;
	} step_t;

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_SRCH_RD  = 8'b0000_0100,
		ST_SRCH_CHK = 8'b0000_1000,
		ST_WALK_RD  = 8'b0001_0000,
		ST_WALK_CHK = 8'b0010_0000,
		ST_MARK     = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

endpackage

// ===== rtl/cpca_ram.sv =====
module cpca_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                          wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                          rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/cigar_path_coverage_accumulator.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready   | req_type, segment_base, segment_length, segment_reverse,
//         |                       | target_start, op_code, op_length, read_address
// out     | out_valid / out_ready | status, depth
//
// after reset the coverage memory is swept to zero, entry by entry, with in_ready low
// clear, append, read and unused requests go straight to the result; an accepted start
// checks each step in turn for the target; a cigar op checks each step visited, skips bases
// at once and counts each marked base through the memory's single read-modify-write port
// a result waits in the output register; the next transaction is taken meanwhile and
// stalls only when its own result is ready and the register is still full
// COVER_DEPTH is a power of two; store addresses wrap modulo COVER_DEPTH
module cigar_path_coverage_accumulator
	import cpca_pkg::*;
#(
	parameter int COVER_DEPTH = 65536,
	parameter int MAX_STEPS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [BASE_W-1:0]   segment_base,
	input  logic [SLEN_W-1:0]   segment_length,
	input  logic                segment_reverse,
	input  logic [TGT_W-1:0]    target_start,
	input  logic [OPC_W-1:0]    op_code,
	input  logic [OPLEN_W-1:0]  op_length,
	input  logic [RADDR_W-1:0]  read_address,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [CNT_W-1:0]    depth
);

	localparam int AW = $clog2(COVER_DEPTH);
	localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int CW = $clog2(MAX_STEPS + 1);

	function automatic logic [AW-1:0] wrap_addr(input logic [SLEN_W:0] x);
		logic [AW+SLEN_W:0] ext;
		ext = {{AW{1'b0}}, x};
		return ext[AW-1:0];
	endfunction

	state_t               state_q;
	logic [AW-1:0]        clr_addr_q;
	logic [CW-1:0]        step_count_q;
	logic [PSTART_W-1:0]  path_total_q;
	logic [IW-1:0]        cur_step_q;
	logic [IW-1:0]        idx_q;
	logic [SLEN_W-1:0]    offset_q;
	logic                 walk_active_q;
	logic                 mark_q;
	logic                 is_read_q;
	logic [TGT_W-1:0]     target_q;
	logic [OPLEN_W-1:0]   len_q;
	logic [STAT_W-1:0]    res_status_q;
	logic                 out_valid_q;
	logic [STAT_W-1:0]    status_q;
	logic [CNT_W-1:0]     depth_q;

	// read-modify-write pipeline of the coverage memory
	logic                 v_s1;
	logic [AW-1:0]        addr_s1;
	logic                 fwd_v_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [CNT_W-1:0]     fwd_data_q;

	logic                 accept;
	logic                 full;
	logic                 start_reject;
	logic                 op_mark;
	logic                 op_skip;
	logic                 op_go;
	logic                 load_out;
	logic [PSTART_W:0]    total_sum;
	logic [PSTART_W-1:0]  total_next;

	step_t                step_wdata;
	step_t                step_rd;
	logic                 step_we;
	logic                 step_re;
	logic [IW-1:0]        step_raddr;

	logic [PSTART_W:0]    seg_end;
	logic                 srch_hit;
	logic                 srch_last;
	logic [PSTART_W-1:0]  srch_diff;

	logic                 past_end;
	logic                 last_step;
	logic [SLEN_W-1:0]    rem;
	logic                 len_fits;
	logic                 mark_last;
	logic [SLEN_W-1:0]    pos_rev;
	logic [SLEN_W:0]      mark_sum;

	logic                 cov_we;
	logic [AW-1:0]        cov_waddr;
	logic [CNT_W-1:0]     cov_wdata;
	logic                 cov_re;
	logic [AW-1:0]        cov_raddr;
	logic [CNT_W-1:0]     cov_rdata;
	logic [CNT_W-1:0]     cur_cnt;
	logic [CNT_W-1:0]     inc_cnt;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign depth     = depth_q;

	assign full         = (step_count_q == CW'(MAX_STEPS));
	assign start_reject = (step_count_q == '0) || (PSTART_W'(target_start) >= path_total_q);
	assign op_mark      = op_code inside {OP_M, OP_EQ, OP_X};
	assign op_skip      = op_code inside {OP_D, OP_N};
	assign op_go        = walk_active_q && (op_mark || op_skip) && (op_length != '0);
	assign load_out     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign total_sum  = (PSTART_W+1)'(path_total_q) + (PSTART_W+1)'(segment_length);
	assign total_next = total_sum[PSTART_W] ? PATH_MAX_TOTAL : total_sum[PSTART_W-1:0];

	// step table
	assign step_wdata = '{base: segment_base, len: segment_length,
		start: path_total_q, rev: segment_reverse};
	assign step_we    = accept && (req_type == REQ_APPEND) && !full;
	assign step_re    = (state_q == ST_SRCH_RD) || (state_q == ST_WALK_RD);
	assign step_raddr = (state_q == ST_SRCH_RD) ? idx_q : cur_step_q;

	cpca_ram #(
		.DATA_W ($bits(step_t)),
		.DEPTH  (MAX_STEPS)
	) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (step_count_q[IW-1:0]),
		.wdata (step_wdata),
		.re    (step_re),
		.raddr (step_raddr),
		.rdata (step_rd)
	);

	// start search
	assign seg_end   = (PSTART_W+1)'(step_rd.start) + (PSTART_W+1)'(step_rd.len);
	assign srch_hit  = (PSTART_W+1)'(target_q) < seg_end;
	assign srch_last = (CW'(idx_q) + CW'(1)) == step_count_q;
	assign srch_diff = PSTART_W'(target_q) - step_rd.start;

	// walk
	assign past_end  = (offset_q >= step_rd.len);
	assign last_step = (CW'(cur_step_q) + CW'(1)) == step_count_q;
	assign rem       = step_rd.len - offset_q;
	assign len_fits  = (len_q <= OPLEN_W'(rem));
	assign mark_last = ((offset_q + SLEN_W'(1)) == step_rd.len) || (len_q == OPLEN_W'(1));
	assign pos_rev   = step_rd.len - SLEN_W'(1) - offset_q;
	assign mark_sum  = (SLEN_W+1)'(step_rd.base)
		+ (SLEN_W+1)'(step_rd.rev ? pos_rev : offset_q);

	// coverage memory ports
	assign cov_re    = (state_q == ST_MARK) || (accept && (req_type == REQ_READ));
	assign cov_raddr = (state_q == ST_MARK) ? wrap_addr(mark_sum)
		: wrap_addr((SLEN_W+1)'(read_address));

	// a write in the previous cycle to the same entry is not yet in the read data
	assign cur_cnt = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : cov_rdata;
	assign inc_cnt = (cur_cnt == SAT_COUNT) ? cur_cnt : cur_cnt + CNT_W'(1);

	assign cov_we    = (state_q == ST_CLEAR) || v_s1;
	assign cov_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s1;
	assign cov_wdata = (state_q == ST_CLEAR) ? '0 : inc_cnt;

	cpca_ram #(
		.DATA_W (CNT_W),
		.DEPTH  (COVER_DEPTH)
	) u_cov_ram (
		.clk   (clk),
		.we    (cov_we),
		.waddr (cov_waddr),
		.wdata (cov_wdata),
		.re    (cov_re),
		.raddr (cov_raddr),
		.rdata (cov_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			step_count_q  <= '0;
			path_total_q  <= '0;
			cur_step_q    <= '0;
			offset_q      <= '0;
			walk_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
			v_s1          <= 1'b0;
			fwd_v_q       <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_MARK);
			fwd_v_q <= v_s1;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(COVER_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DONE;
						unique case (req_type)
							REQ_CLEAR: begin
								step_count_q  <= '0;
								path_total_q  <= '0;
								walk_active_q <= 1'b0;
							end
							REQ_APPEND: begin
								if (!full) begin
									step_count_q <= step_count_q + CW'(1);
									path_total_q <= total_next;
								end
							end
							REQ_START: begin
								walk_active_q <= 1'b0;
								if (!start_reject)
									state_q <= ST_SRCH_RD;
							end
							REQ_OP: begin
								if (op_go)
									state_q <= ST_WALK_RD;
							end
							default: ;
						endcase
					end
				end
				ST_SRCH_RD: state_q <= ST_SRCH_CHK;
				ST_SRCH_CHK: begin
					if (srch_hit) begin
						cur_step_q    <= idx_q;
						offset_q      <= srch_diff[SLEN_W-1:0];
						walk_active_q <= 1'b1;
						state_q       <= ST_DONE;
					end else if (srch_last) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SRCH_RD;
					end
				end
				ST_WALK_RD: state_q <= ST_WALK_CHK;
				ST_WALK_CHK: begin
					if (len_q == '0) begin
						state_q <= ST_DONE;
					end else if (past_end) begin
						if (last_step) begin
							walk_active_q <= 1'b0;
							state_q       <= ST_DONE;
						end else begin
							cur_step_q <= cur_step_q + IW'(1);
							offset_q   <= '0;
							state_q    <= ST_WALK_RD;
						end
					end else if (mark_q) begin
						state_q <= ST_MARK;
					end else begin
						// skip the rest of the op or the rest of this step at once
						offset_q <= len_fits ? offset_q + len_q[SLEN_W-1:0] : step_rd.len;
					end
				end
				ST_MARK: begin
					offset_q <= offset_q + SLEN_W'(1);
					if (mark_last)
						state_q <= ST_WALK_CHK;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= cov_raddr;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= inc_cnt;

		if (accept) begin
			target_q  <= target_start;
			len_q     <= op_length;
			mark_q    <= op_mark;
			is_read_q <= (req_type == REQ_READ);
			idx_q     <= '0;
			case (req_type)
				REQ_APPEND: res_status_q <= full ? STAT_FULL : STAT_OK;
				REQ_START:  res_status_q <= start_reject ? STAT_REJECT : STAT_OK;
				REQ_OP:     res_status_q <= walk_active_q ? STAT_OK : STAT_NO_WALK;
				default:    res_status_q <= STAT_OK;
			endcase
		end

		if ((state_q == ST_SRCH_CHK) && !srch_hit) begin
			idx_q <= idx_q + IW'(1);
			if (srch_last)
				res_status_q <= STAT_REJECT;
		end

		if ((state_q == ST_WALK_CHK) && (len_q != '0) && !past_end && !mark_q)
			len_q <= len_fits ? '0 : len_q - OPLEN_W'(rem);

		if (state_q == ST_MARK)
			len_q <= len_q - OPLEN_W'(1);

		if (load_out) begin
			status_q <= res_status_q;
			depth_q  <= is_read_q ? cov_rdata : '0;
		end
	end

	a_mark_needs_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> walk_active_q)
		else $error("coverage marking without an active walk");

	a_no_rmw_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !v_s1)
		else $error("read-modify-write during the clearing sweep");

	a_rmw_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !v_s1)
		else $error("result ready with a coverage write still in flight");

	a_step_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		walk_active_q |-> (CW'(cur_step_q) < step_count_q))
		else $error("active walk points past the last step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |=> (step_count_q == $past(step_count_q)))
		else $error("step table changed during a walk");

endmodule
